// File: src/ede_pkg.sv
// Shared types and constants for the Euclidean distance engine.
package ede_pkg;

    // Field widths of the streaming interface.
    localparam int ELEM_W  = 24;
    localparam int SUM_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int COUNT_W = 11;

    // Derived datapath widths.
    localparam int MAG_W = ELEM_W + 1;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int REM_W = ROOT_W + 2;

    // Depth of the queue between the accumulator and the square root unit.
    localparam int QUEUE_DEPTH = 2;

    // One input request: a pair of vector elements.
    typedef struct packed {
        logic signed [ELEM_W-1:0] elem_a;
        logic signed [ELEM_W-1:0] elem_b;
        logic                     last_element;
    } in_item_t;

    // One result request.
    typedef struct packed {
        logic [ROOT_W-1:0]  distance;
        logic               saturated;
        logic [COUNT_W-1:0] element_count;
    } out_item_t;

    // A finished accumulation waiting for its square root.
    typedef struct packed {
        logic [SUM_W-1:0]   square_sum;
        logic               saturated;
        logic [COUNT_W-1:0] element_count;
    } acc_entry_t;

endpackage

// File: src/ede_front.sv
// Front part: accepts element pairs, squares the differences and accumulates.
module ede_front #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                norm_mode,
    input  logic                in_valid,
    output logic                in_stall,
    input  ede_pkg::in_item_t   in_data,
    input  logic                q_full,
    output logic                push,
    output ede_pkg::acc_entry_t push_entry
);
    import ede_pkg::*;

    localparam int               CNT_W   = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);

    logic             advance;
    logic             accept;
    logic [MAG_W-1:0] diff;
    logic [MAG_W-1:0] mag;
    logic [SQ_W-1:0]  sq;
    logic [SUM_W:0]   sum_ext;
    logic [SUM_W-1:0] sum_sat;
    logic             ovf_new;
    logic [CNT_W-1:0] cnt_new;

    logic             s1_valid_reg;
    logic             s1_last_reg;
    logic [MAG_W-1:0] mag_reg;
    logic             s2_valid_reg;
    logic             s2_last_reg;
    logic [SQ_W-1:0]  sq_reg;
    logic [SUM_W-1:0] sum_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] cnt_reg;

    // The pipeline holds only when a finished vector cannot enter the queue.
    assign advance  = !(s2_valid_reg && s2_last_reg && q_full);
    assign in_stall = !advance;
    assign accept   = in_valid && advance;

    // Difference and its magnitude; norm mode takes the second element as zero.
    always_comb
    begin
        diff = {in_data.elem_a[ELEM_W-1], in_data.elem_a}
             - (norm_mode ? {MAG_W{1'b0}} : {in_data.elem_b[ELEM_W-1], in_data.elem_b});
        mag  = diff[MAG_W-1] ? (~diff + 1'b1) : diff;
    end

    // Square of the registered magnitude.
    assign sq = SQ_W'(mag_reg) * SQ_W'(mag_reg);

    // Saturating accumulation and saturating pair count.
    always_comb
    begin
        sum_ext = {1'b0, sum_reg} + (SUM_W + 1)'(sq_reg);
        sum_sat = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
        ovf_new = ovf_reg | sum_ext[SUM_W];
        cnt_new = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
    end

    // A vector is complete when its last pair reaches the accumulator.
    assign push                     = s2_valid_reg && s2_last_reg && !q_full;
    assign push_entry.square_sum    = sum_sat;
    assign push_entry.saturated     = ovf_new;
    assign push_entry.element_count = COUNT_W'(cnt_new);

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mag_reg     <= mag;
            s1_last_reg <= in_data.last_element;
            sq_reg      <= sq;
            s2_last_reg <= s1_last_reg;
        end
    end

    // Accumulator state, cleared after each finished vector.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            ovf_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (advance && s2_valid_reg)
        begin
            if (s2_last_reg)
            begin
                sum_reg <= '0;
                ovf_reg <= 1'b0;
                cnt_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_sat;
                ovf_reg <= ovf_new;
                cnt_reg <= cnt_new;
            end
        end
    end

endmodule

// File: src/ede_queue.sv
// Short queue of finished accumulations between the front and the back part.
module ede_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ede_pkg::acc_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output ede_pkg::acc_entry_t head_entry
);
    import ede_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    acc_entry_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: src/ede_sqrt.sv
// Back part: digit-by-digit integer square root and the result register.
module ede_sqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  ede_pkg::acc_entry_t head_entry,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output ede_pkg::out_item_t  out_data
);
    import ede_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam int               STEP_W    = $clog2(ROOT_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ROOT_W - 1);

    logic [1:0]         state_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [SUM_W-1:0]   rad_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic               sat_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    logic [REM_W-1:0]   rem_shift;
    logic [REM_W-1:0]   trial;
    logic               take;
    logic               out_free;
    logic               load_out;

    assign pop       = (state_reg == ST_IDLE) && head_valid;
    assign out_free  = !out_valid_reg || !out_stall;
    assign load_out  = (state_reg == ST_DONE) && out_free;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // One root bit per step: bring down two radicand bits and try a subtract.
    always_comb
    begin
        rem_shift = {rem_reg[REM_W-3:0], rad_reg[SUM_W-1:SUM_W-2]};
        trial     = {root_reg, 2'b01};
        take      = (rem_shift >= trial);
    end

    // Sequencer of the root unit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (head_valid)
                    begin
                        state_reg <= ST_BUSY;
                        step_reg  <= '0;
                    end
                end
                ST_BUSY:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_LAST)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Root datapath.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rad_reg  <= head_entry.square_sum;
            rem_reg  <= '0;
            root_reg <= '0;
            sat_reg  <= head_entry.saturated;
            cnt_reg  <= head_entry.element_count;
        end
        else if (state_reg == ST_BUSY)
        begin
            rad_reg  <= {rad_reg[SUM_W-3:0], 2'b00};
            rem_reg  <= take ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

    // Result register, held while the receiver stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg.distance      <= root_reg;
            out_data_reg.saturated     <= sat_reg;
            out_data_reg.element_count <= cnt_reg;
        end
    end

endmodule

// File: src/euclidean_distance_engine.sv
// Top level of the streaming Euclidean distance / L2 norm engine.
// Throughput: one element pair per cycle while in_stall is low; one sum is rooted at a time.
// The root unit works through 32 root steps for each result.
// Two finished vectors may wait in the queue before the input stalls.
// Reset (asynchronous, active low) clears the accumulator, queue, root unit and norm_mode.
// Pipeline and result payload registers are not reset.
module euclidean_distance_engine #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  ede_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ede_pkg::out_item_t out_data
);
    import ede_pkg::*;

    logic       norm_mode_reg;
    logic       q_push;
    acc_entry_t q_push_entry;
    logic       q_full;
    logic       q_pop;
    logic       q_head_valid;
    acc_entry_t q_head_entry;

    // Mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            norm_mode_reg <= cfg_wdata;
        end
    end

    // Accumulating front part.
    ede_front #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .norm_mode (norm_mode_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .q_full    (q_full),
        .push      (q_push),
        .push_entry(q_push_entry)
    );

    // Queue of finished sums.
    ede_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_entry(q_push_entry),
        .full      (q_full),
        .pop       (q_pop),
        .head_valid(q_head_valid),
        .head_entry(q_head_entry)
    );

    // Square root back part.
    ede_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(q_head_valid),
        .head_entry(q_head_entry),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef SYNTH
    // The front never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_full))
        else $error("push into full queue");

    // A saturated sum always yields the largest root.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.saturated) |-> (out_data.distance == {ROOT_W{1'b1}}))
        else $error("saturated result with wrong distance");

    // Every result counts at least one pair and no more than the limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.element_count != '0
                       && out_data.element_count <= COUNT_W'(MAX_ELEMENTS)))
        else $error("element count out of range");

    // The root unit only takes a sum that is present.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_head_valid)
        else $error("pop from empty queue");
`endif

endmodule

// File: tb/ede_checker.sv
// Checker for the Euclidean distance engine: watches both channels, predicts and compares.
module ede_checker #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               in_valid,
    input  logic               in_stall,
    input  ede_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  ede_pkg::out_item_t out_data,
    output int                 fail_count,
    output int                 pending_count,
    output int                 results_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import ede_pkg::*;

    // Results predicted but not yet seen on the output channel.
    out_item_t expected_distances[$];

    // Shadow of the accumulator and the mode register.
    logic [SUM_W-1:0]   acc_sum;
    logic [COUNT_W-1:0] acc_pairs;
    logic               acc_clipped;
    logic               norm_shadow;

    int fails = 0;
    int depth = 0;
    int seen  = 0;

    logic [SUM_W:0] wide_sum;
    out_item_t      want;

    assign fail_count      = fails;
    assign pending_count   = depth;
    assign results_checked = seen;

    // Square of the element difference; the second element counts as zero in norm mode.
    function automatic logic [SQ_W-1:0] diff_square(input in_item_t item, input logic ignore_b);
        logic signed [MAG_W-1:0] ext_a;
        logic signed [MAG_W-1:0] ext_b;
        logic signed [MAG_W-1:0] diff;
        logic        [MAG_W-1:0] mag;
        ext_a = {item.elem_a[ELEM_W-1], item.elem_a};
        ext_b = ignore_b ? '0 : {item.elem_b[ELEM_W-1], item.elem_b};
        diff  = ext_a - ext_b;
        mag   = diff[MAG_W-1] ? -diff : diff;
        return SQ_W'(mag) * SQ_W'(mag);
    endfunction

    // Floor of the square root, built one result bit at a time from the top.
    function automatic logic [ROOT_W-1:0] floor_root(input logic [SUM_W-1:0] x);
        logic [ROOT_W-1:0] root;
        logic [ROOT_W-1:0] trial;
        root = '0;
        for (int i = ROOT_W - 1; i >= 0; i--)
        begin
            trial = root | (ROOT_W'(1) << i);
            if (SUM_W'(trial) * SUM_W'(trial) <= x)
                root = trial;
        end
        return root;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_sum     = '0;
            acc_pairs   = '0;
            acc_clipped = 1'b0;
            norm_shadow = 1'b0;
            expected_distances.delete();
            depth = 0;
        end
        else
        begin
            // Accumulate every accepted input request with the mode in force before this edge.
            if (in_valid && !in_stall)
            begin
                wide_sum = {1'b0, acc_sum} + (SUM_W + 1)'(diff_square(in_data, norm_shadow));
                if (wide_sum[SUM_W])
                begin
                    acc_sum     = '1;
                    acc_clipped = 1'b1;
                end
                else
                    acc_sum = wide_sum[SUM_W-1:0];
                if (acc_pairs < COUNT_W'(MAX_ELEMENTS))
                    acc_pairs = acc_pairs + 1'b1;
                if (in_data.last_element)
                begin
                    want.distance      = floor_root(acc_sum);
                    want.saturated     = acc_clipped;
                    want.element_count = acc_pairs;
                    expected_distances.push_back(want);
                    acc_sum     = '0;
                    acc_pairs   = '0;
                    acc_clipped = 1'b0;
                end
            end

            // Register writes must happen only while the engine is idle; the engine does not enforce this.
            if (cfg_we)
                norm_shadow = cfg_wdata;

            // Compare every accepted result request with the oldest prediction.
            if (out_valid && !out_stall)
            begin
                if (expected_distances.size() == 0)
                begin
                    fails++;
                    $display("%0t ns: unexpected result request, expected none, got %h",
                             $time, out_data);
                end
                else
                begin
                    want = expected_distances.pop_front();
                    seen++;
                    if (out_data.distance !== want.distance)
                    begin
                        fails++;
                        $display("%0t ns: distance mismatch, expected %0d, got %0d",
                                 $time, want.distance, out_data.distance);
                    end
                    if (out_data.saturated !== want.saturated)
                    begin
                        fails++;
                        $display("%0t ns: saturated mismatch, expected %b, got %b",
                                 $time, want.saturated, out_data.saturated);
                    end
                    if (out_data.element_count !== want.element_count)
                    begin
                        fails++;
                        $display("%0t ns: element_count mismatch, expected %0d, got %0d",
                                 $time, want.element_count, out_data.element_count);
                    end
                end
            end
            depth = expected_distances.size();
        end
    end

endmodule

// File: tb/tb_euclidean_distance_engine.sv
// Top of the Euclidean distance engine testbench: clock, reset, stimulus and verdict.
module tb_euclidean_distance_engine;
    timeunit 1ns;
    timeprecision 1ps;
    import ede_pkg::*;

    localparam int  CYCLE_LIMIT   = 1000000;
    localparam int  SETTLE_CYCLES = 48;
    localparam int  RANDOM_ITEMS  = 650;
    localparam int  CLAMP_LENGTH  = 1030;
    localparam logic [ELEM_W-1:0] ELEM_MAX = 24'h7FFFFF;
    localparam logic [ELEM_W-1:0] ELEM_MIN = 24'h800000;
    localparam logic MODE_DISTANCE = 1'b0;
    localparam logic MODE_NORM     = 1'b1;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cfg_we    = 1'b0;
    logic      cfg_wdata = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    int  fail_count;
    int  pending_count;
    int  results_checked;
    int  pairs_sent   = 0;
    int  vectors_sent = 0;
    int  cycle_count  = 0;
    bit  send_gaps    = 1'b0;
    bit  recv_gaps    = 1'b0;

    euclidean_distance_engine DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    ede_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .fail_count     (fail_count),
        .pending_count  (pending_count),
        .results_checked(results_checked)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Output backpressure in random bursts, decided at the rising edge.
    always
    begin
        @(posedge clk);
        if (recv_gaps && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            out_stall <= 1'b0;
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Element values weighted toward the ends of the range and small magnitudes.
    function automatic logic [ELEM_W-1:0] pick_elem(input int style);
        logic [ELEM_W-1:0] v;
        v = ELEM_W'($urandom());
        case (style)
            1:
            begin
                case ($urandom_range(0, 5))
                    0: v = ELEM_MAX;
                    1: v = ELEM_MIN;
                    2: v = '0;
                    3: v = '1;
                    default: v = ELEM_W'($urandom());
                endcase
            end
            2: v = ELEM_W'($signed($urandom_range(0, 8191)) - 4096);
            default: v = ELEM_W'($urandom());
        endcase
        return v;
    endfunction

    // Send one element pair request, with an optional idle burst before it.
    task automatic push_pair(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b,
                             input logic last);
        if (send_gaps && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {a, b, last};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        pairs_sent++;
        if (last)
            vectors_sent++;
    endtask

    // Stop sending and wait until every predicted result is out, plus the root latency.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_norm_mode(input logic mode);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One vector of the given length; style picks how the elements relate.
    task automatic send_vector(input int len, input int style);
        logic [ELEM_W-1:0] a;
        logic [ELEM_W-1:0] b;
        for (int k = 0; k < len; k++)
        begin
            a = pick_elem(style);
            b = pick_elem(style);
            if (style == 3)
                b = ($urandom_range(0, 3) == 0) ? a : a + ELEM_W'($urandom_range(0, 63));
            push_pair(a, b, k == len - 1);
        end
    endtask

    initial
    begin
        int len;
        int phase_start;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed distance cases: extremes, zero, equal pairs, one LSB, a short vector.
        set_norm_mode(MODE_DISTANCE);
        push_pair(ELEM_MAX, ELEM_MIN, 1'b1);
        push_pair(ELEM_MIN, ELEM_MAX, 1'b1);
        push_pair('0, '0, 1'b1);
        push_pair(24'h123456, 24'h123456, 1'b1);
        push_pair(24'h000001, '0, 1'b1);
        push_pair(ELEM_MAX, ELEM_MAX, 1'b0);
        push_pair(ELEM_MIN, '0, 1'b0);
        push_pair('1, 24'h000001, 1'b1);

        // Directed norm cases: the second element must have no effect.
        set_norm_mode(MODE_NORM);
        push_pair(ELEM_MIN, ELEM_MAX, 1'b1);
        push_pair(ELEM_MAX, ELEM_MIN, 1'b1);
        push_pair('0, ELEM_MAX, 1'b1);
        push_pair(24'h000005, ELEM_MAX, 1'b0);
        push_pair(24'hFFFFFB, '0, 1'b1);

        // Count clamp: a vector longer than the maximum length.
        set_norm_mode(MODE_DISTANCE);
        send_vector(CLAMP_LENGTH, 0);

        // Random vectors over alternating modes; the last phase runs without idling.
        for (int phase = 0; phase < 5; phase++)
        begin
            set_norm_mode(phase[0] ? MODE_NORM : MODE_DISTANCE);
            phase_start = pairs_sent;
            while (pairs_sent - phase_start < RANDOM_ITEMS / 5)
            begin
                send_gaps = (phase < 4) && ($urandom_range(0, 9) < 7);
                recv_gaps = (phase < 4) && ($urandom_range(0, 3) != 0);
                case ($urandom_range(0, 19))
                    0: len = $urandom_range(61, 300);
                    1, 2, 3, 4: len = $urandom_range(11, 60);
                    default: len = $urandom_range(1, 10);
                endcase
                send_vector(len, $urandom_range(0, 3));
            end
        end
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        settle();

        $display("Sent %0d element pair requests in %0d vectors; %0d results checked.",
                 pairs_sent, vectors_sent, results_checked);
        $display("Both modes, field extremes, near and equal pairs and the count clamp were covered.");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
